// ===== hdl/lwts_pkg.sv =====
// ----------------------------------------------------------------------------
// lwts_pkg
// Shared types and constants for the waiting time sampler.
// ----------------------------------------------------------------------------
package lwts_pkg;

  localparam int MAX_ITER_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 8;

  localparam logic [24:0] LN2_Q24 = 25'd11629080;
  localparam logic [63:0] QL_CAP  = 64'h0010_0000_0000_0000;
  localparam logic [63:0] T_CAP   = 64'h4000_0000_0000_0000;
  localparam logic signed [63:0] Y_CAP = 64'sh0080_0000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_RATE  = 8'd0,
    REG_COUNT_GAIN = 8'd1,
    REG_EXTRA_RATE = 8'd2,
    REG_TOLERANCE  = 8'd3
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] uniform_sample;
    logic [31:0] elapsed_time;
    logic [15:0] current_count;
    logic [15:0] population;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] waiting_time;
    logic               converged;
  } out_beat_t;

endpackage

// ===== hdl/lwts_muldiv.sv =====
// ----------------------------------------------------------------------------
// lwts_muldiv
// Sequential floor(a*b/d) saturated at cap: four 32x32 partial products,
// then a restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lwts_muldiv import lwts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [63:0] d,
  input  logic [63:0] cap,
  output logic        done,
  output logic [63:0] result
);

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_MUL  = 3'b010,
    M_DIV  = 3'b100
  } md_state_t;

  md_state_t    state;
  logic [63:0]  a_r, b_r, d_r, cap_r;
  logic [127:0] acc;
  logic [63:0]  rem;
  logic [63:0]  lo;
  logic [6:0]   cnt;
  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [6:0]   sh;
  logic [64:0]  rem2;
  logic [63:0]  quo_fin;

  assign a_part  = cnt[0] ? a_r[63:32] : a_r[31:0];
  assign b_part  = cnt[1] ? b_r[63:32] : b_r[31:0];
  assign pp      = a_part * b_part;
  assign sh      = 7'(({1'b0, cnt[0]} + {1'b0, cnt[1]}) * 32);
  assign rem2    = {rem, lo[63]};
  assign quo_fin = (rem2 >= {1'b0, d_r}) ? {lo[62:0], 1'b1} : {lo[62:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            a_r   <= a;
            b_r   <= b;
            d_r   <= d;
            cap_r <= cap;
            acc   <= '0;
            cnt   <= '0;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          if (cnt == 7'd3) begin
            if ((acc + ({64'b0, pp} << sh)) >> 64 >= {64'b0, d_r}) begin
              result <= cap_r;
              done   <= 1'b1;
              state  <= M_IDLE;
            end else begin
              rem   <= acc[127:64] + 64'((({64'b0, pp} << sh)) >> 64) +
                       64'(({1'b0, acc[63:0]} + {1'b0, 64'((({64'b0, pp} << sh)))}) >> 64);
              lo    <= acc[63:0] + 64'(({64'b0, pp} << sh));
              cnt   <= '0;
              state <= M_DIV;
            end
          end else begin
            acc <= acc + ({64'b0, pp} << sh);
            cnt <= cnt + 7'd1;
          end
        end
        M_DIV: begin
          if (rem2 >= {1'b0, d_r}) begin
            rem <= 64'(rem2 - {1'b0, d_r});
            lo  <= {lo[62:0], 1'b1};
          end else begin
            rem <= rem2[63:0];
            lo  <= {lo[62:0], 1'b0};
          end
          if (cnt == 7'd63) begin
            result <= (quo_fin > cap_r) ? cap_r : quo_fin;
            done   <= 1'b1;
            state  <= M_IDLE;
          end
          cnt <= cnt + 7'd1;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/lwts_ln.sv =====
// ----------------------------------------------------------------------------
// lwts_ln
// Sequential natural log of x / 2^scale: leading-one search, 24 mantissa
// squarings for the log2 fraction, one multiply by ln 2.
// ----------------------------------------------------------------------------
module lwts_ln import lwts_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [63:0]        x,
  input  logic [5:0]         scale,
  output logic               done,
  output logic signed [63:0] result
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_NORM = 4'b0010,
    L_SQR  = 4'b0100,
    L_MUL  = 4'b1000
  } ln_state_t;

  ln_state_t          state;
  logic [63:0]        norm;
  logic [6:0]         lz;
  logic [4:0]         k;
  logic [5:0]         scale_r;
  logic [30:0]        m;
  logic [23:0]        frac;
  logic [6:0]         s;
  logic [63:0]        top_mask;
  logic [61:0]        sq;
  logic [31:0]        sq_t;
  logic [7:0]         ps;
  logic signed [31:0] l2;
  logic signed [57:0] lp;

  assign s        = 7'd32 >> k[2:0];
  assign top_mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> s);
  assign sq       = m * m;
  assign sq_t     = sq[61:30];
  assign ps       = 8'(7'd63 - lz) - {2'b0, scale_r};
  assign l2       = $signed({ps, frac});
  assign lp       = l2 * $signed({1'b0, LN2_Q24});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            norm    <= x;
            scale_r <= scale;
            lz      <= '0;
            k       <= '0;
            state   <= L_NORM;
          end
        end
        L_NORM: begin
          if ((norm & top_mask) == 64'd0) begin
            norm <= norm << s;
            lz   <= lz + s;
          end
          if (k == 5'd5) begin
            k     <= '0;
            state <= L_SQR;
          end else begin
            k <= k + 5'd1;
          end
        end
        L_SQR: begin
          if (k == 5'd0) begin
            m    <= norm[63:33];
            frac <= '0;
            k    <= 5'd1;
          end else begin
            if (sq_t[31]) begin
              m    <= sq_t[31:1];
              frac <= {frac[22:0], 1'b1};
            end else begin
              m    <= sq_t[30:0];
              frac <= {frac[22:0], 1'b0};
            end
            if (k == 5'd24) begin
              state <= L_MUL;
            end
            k <= k + 5'd1;
          end
        end
        L_MUL: begin
          result <= 64'(lp >>> (48 - FRAC_BITS));
          done   <= 1'b1;
          state  <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/lambert_waiting_time_sampler.sv =====
// ----------------------------------------------------------------------------
// lambert_waiting_time_sampler
// Samples a waiting time by solving ln y + y = c with Newton steps on one
// shared log unit and one shared multiply-divide unit.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake
//  in_*     | into      | in_valid / in_stall
//  out_*    | out of    | out_valid / out_stall
//  cfg_*    | into      | cfg_valid / cfg_ready
// An input beat runs three multiply-divides and two logs outside the
// Newton loop, plus one log and one multiply-divide per Newton step,
// for up to MAX_ITER steps.
// Reset is synchronous and restores the register defaults.
// in_stall stays high from acceptance until the result is loaded into the
// output register; a stalled result holds there.
module lambert_waiting_time_sampler import lwts_pkg::*; #(
  parameter int MAX_ITER  = MAX_ITER_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int          IW    = $clog2(MAX_ITER + 1);
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SETUP = 10'b00_0000_0010,
    S_Q     = 10'b00_0000_0100,
    S_LNR   = 10'b00_0000_1000,
    S_LT    = 10'b00_0001_0000,
    S_LNQ   = 10'b00_0010_0000,
    S_LNY   = 10'b00_0100_0000,
    S_DEL   = 10'b00_1000_0000,
    S_PROD  = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state;

  logic [31:0] base_rate, count_gain, extra_rate;
  logic [15:0] tolerance;

  logic [31:0] r, h;
  logic [15:0] cur, pop;
  logic [63:0] summ, acurr, q, lterm;
  logic signed [63:0] c, y;
  logic [IW-1:0] n;
  logic conv;
  out_beat_t pending;

  logic        md_start, md_done;
  logic [63:0] md_a, md_b, md_d, md_cap, md_res;
  logic        ln_start, ln_done;
  logic [63:0] ln_x;
  logic [5:0]  ln_scale;
  logic signed [63:0] ln_res;

  logic [63:0] summ_w, acurr_w;
  logic [47:0] acurr_p;
  logic signed [63:0] c_w, f_w, delta, ny_raw, ny, step, t_w;
  logic [63:0] mag_w;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  assign summ_w  = ({48'b0, pop} << FRAC_BITS) + {32'b0, extra_rate} + {32'b0, base_rate};
  assign acurr_p = count_gain * cur;
  assign acurr_w = {16'b0, acurr_p};
  assign c_w     = ln_res + $signed(lterm) + $signed(q);
  assign f_w     = ln_res + y - c;
  assign mag_w   = f_w[63] ? 64'(-f_w) : f_w;
  assign delta   = $signed(md_res);
  assign ny_raw  = f_w[63] ? y + delta : y - delta;
  assign ny      = (ny_raw < 64'sd1) ? 64'sd1 : ((ny_raw > Y_CAP) ? Y_CAP : ny_raw);
  assign step    = (ny > y) ? ny - y : y - ny;
  assign t_w     = $signed(md_res) - $signed({32'b0, h});

  lwts_muldiv u_md (
    .clk(clk), .rst(rst), .start(md_start), .a(md_a), .b(md_b), .d(md_d),
    .cap(md_cap), .done(md_done), .result(md_res)
  );

  lwts_ln #(.FRAC_BITS(FRAC_BITS)) u_ln (
    .clk(clk), .rst(rst), .start(ln_start), .x(ln_x), .scale(ln_scale),
    .done(ln_done), .result(ln_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_rate  <= 32'd65536;
      count_gain <= 32'd65536;
      extra_rate <= 32'd0;
      tolerance  <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_RATE:  base_rate  <= cfg_data;
        REG_COUNT_GAIN: count_gain <= cfg_data;
        REG_EXTRA_RATE: extra_rate <= cfg_data;
        REG_TOLERANCE:  tolerance  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      md_start  <= 1'b0;
      ln_start  <= 1'b0;
    end else begin
      md_start <= 1'b0;
      ln_start <= 1'b0;
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            r     <= in_data.uniform_sample;
            h     <= in_data.elapsed_time;
            cur   <= in_data.current_count;
            pop   <= in_data.population;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          summ     <= (summ_w == 64'd0) ? 64'd1 : summ_w;
          acurr    <= (acurr_w == 64'd0) ? 64'd1 : acurr_w;
          md_a     <= {32'b0, h};
          md_b     <= (summ_w == 64'd0) ? 64'd1 : summ_w;
          md_d     <= (acurr_w == 64'd0) ? 64'd1 : acurr_w;
          md_cap   <= QL_CAP;
          md_start <= 1'b1;
          state    <= S_Q;
        end
        S_Q: begin
          if (md_done) begin
            q        <= md_res;
            ln_x     <= 64'(65'h1_0000_0000 - {33'b0, r});
            ln_scale <= 6'd32;
            ln_start <= 1'b1;
            state    <= S_LNR;
          end
        end
        S_LNR: begin
          if (ln_done) begin
            md_a     <= 64'(-ln_res);
            md_b     <= ONE_Q;
            md_d     <= acurr;
            md_cap   <= QL_CAP;
            md_start <= 1'b1;
            state    <= S_LT;
          end
        end
        S_LT: begin
          if (md_done) begin
            lterm    <= md_res;
            ln_x     <= (q == 64'd0) ? 64'd1 : q;
            ln_scale <= 6'(FRAC_BITS);
            ln_start <= 1'b1;
            state    <= S_LNQ;
          end
        end
        S_LNQ: begin
          if (ln_done) begin
            c        <= c_w;
            y        <= (c_w >= $signed(ONE_Q)) ? c_w : 64'sd1;
            ln_x     <= (c_w >= $signed(ONE_Q)) ? c_w : 64'd1;
            n        <= '0;
            conv     <= 1'b0;
            ln_start <= 1'b1;
            state    <= S_LNY;
          end
        end
        S_LNY: begin
          if (ln_done) begin
            md_a     <= mag_w;
            md_b     <= y;
            md_d     <= y + ONE_Q;
            md_cap   <= T_CAP;
            md_start <= 1'b1;
            state    <= S_DEL;
          end
        end
        S_DEL: begin
          if (md_done) begin
            y <= ny;
            if (step <= $signed({48'b0, tolerance}) || n == IW'(MAX_ITER - 1)) begin
              conv     <= (step <= $signed({48'b0, tolerance}));
              md_a     <= acurr;
              md_b     <= ny;
              md_d     <= summ;
              md_cap   <= T_CAP;
              md_start <= 1'b1;
              state    <= S_PROD;
            end else begin
              n        <= n + IW'(1);
              ln_x     <= ny;
              ln_start <= 1'b1;
              state    <= S_LNY;
            end
          end
        end
        S_PROD: begin
          if (md_done) begin
            pending.converged <= conv;
            if (t_w > 64'sh7FFF_FFFF) begin
              pending.waiting_time <= 32'sh7FFF_FFFF;
            end else if (t_w < -64'sh8000_0000) begin
              pending.waiting_time <= 32'sh8000_0000;
            end else begin
              pending.waiting_time <= t_w[31:0];
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data  <= pending;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/lwts_checker.sv =====
// ----------------------------------------------------------------------------
// lwts_checker
// Port-level checks on the sampler, bound to the top level.
// ----------------------------------------------------------------------------
module lwts_checker import lwts_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before work finished");

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat appeared without work in progress");

endmodule

bind lambert_waiting_time_sampler lwts_checker u_lwts_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== bench/tb_lambert_waiting_time_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lambert_waiting_time_sampler
// Drives fraction/time/count/population beats through the sampler under
// bursty input and a patterned output stall, predicts each waiting time and
// converged flag with an in-bench fixed-point Newton solver, and compares
// every output beat in order. Registers are reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_lambert_waiting_time_sampler;
  import lwts_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'd255;
  localparam int  WATCHDOG_LIMIT = 60000;
  localparam int  HOLD_CYCLES    = 4000;
  localparam logic [63:0] ONE_FX = 64'd65536;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_beat_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_beat_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  logic [31:0] base_rate_q, count_gain_q, extra_rate_q;
  logic [15:0] tolerance_q;

  out_beat_t   waits_pending[$];
  int          error_count;
  int          burst_left;
  int          idle_cycles;
  bit          hold_req;
  int          hold_left;
  int          stall_mode;
  int          mode_timer;

  lambert_waiting_time_sampler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] muldiv_sat(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] d, logic [63:0] cap);
    logic [127:0] prod;
    logic [127:0] quo;
    prod = {64'd0, a} * {64'd0, b};
    if (prod[127:64] >= d) return cap;
    quo = prod / {64'd0, d};
    return (quo > {64'd0, cap}) ? cap : quo[63:0];
  endfunction

  // ln(x / 2^scale) with 16 fraction bits
  function automatic longint ln_fixed(logic [63:0] x, int scale);
    int          p;
    logic [63:0] m;
    logic [63:0] frac;
    longint      l2;
    p = 63;
    frac = 64'd0;
    while (p > 0 && !x[p]) p--;
    m = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
    for (int k = 0; k < 24; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    l2 = longint'(p - scale) * 64'sd16777216 + longint'(frac);
    return (l2 * longint'(LN2_Q24)) >>> 32;
  endfunction

  function automatic out_beat_t sample_wait_time(in_beat_t b);
    logic [63:0] summ, acurr, q, lneg, lterm, prod;
    longint      c, y, f, mag, delta, ny, step, t;
    logic        conv;
    out_beat_t   r;
    conv = 1'b0;
    summ = ({48'd0, b.population} << 16) + {32'd0, base_rate_q} + {32'd0, extra_rate_q};
    if (summ == 0) summ = 64'd1;
    acurr = {32'd0, count_gain_q} * {48'd0, b.current_count};
    if (acurr == 0) acurr = 64'd1;
    q = muldiv_sat({32'd0, b.elapsed_time}, summ, acurr, QL_CAP);
    lneg = -ln_fixed((64'd1 << 32) - {32'd0, b.uniform_sample}, 32);
    lterm = muldiv_sat(lneg, ONE_FX, acurr, QL_CAP);
    c = ln_fixed((q == 0) ? 64'd1 : q, 16) + longint'(lterm) + longint'(q);
    y = (c >= longint'(ONE_FX)) ? c : 64'sd1;
    for (int n = 0; n < MAX_ITER_DEF; n++) begin
      f = ln_fixed(y, 16) + y - c;
      mag = (f < 0) ? -f : f;
      delta = longint'(muldiv_sat(mag, y, y + longint'(ONE_FX), T_CAP));
      ny = (f < 0) ? y + delta : y - delta;
      if (ny < 1) ny = 1;
      if (ny > longint'(Y_CAP)) ny = longint'(Y_CAP);
      step = (ny > y) ? ny - y : y - ny;
      y = ny;
      if (step <= longint'(tolerance_q)) begin
        conv = 1'b1;
        break;
      end
    end
    prod = muldiv_sat(acurr, y, summ, T_CAP);
    t = longint'(prod) - longint'({32'd0, b.elapsed_time});
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    r.waiting_time = t[31:0];
    r.converged = conv;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // output checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (waits_pending.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", out_data));
      end else begin
        out_beat_t exp_beat;
        exp_beat = waits_pending.pop_front();
        if (out_data.waiting_time !== exp_beat.waiting_time)
          report_mismatch($sformatf("waiting_time got %h want %h",
                                    out_data.waiting_time, exp_beat.waiting_time));
        if (out_data.converged !== exp_beat.converged)
          report_mismatch($sformatf("converged got %b want %b",
                                    out_data.converged, exp_beat.converged));
      end
    end
  end

  // receiver stall pattern, with a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      stall_mode <= 0;
      mode_timer <= 0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_timer == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_timer <= $urandom_range(200, 3000);
      end else begin
        mode_timer <= mode_timer - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ($urandom_range(0, 99) < 85);
        default: out_stall <= (mode_timer % 7) < 3;
      endcase
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_lambert_waiting_time_sampler: done, errors");
        $finish;
      end
    end
  end

  task automatic send_beat(in_beat_t b);
    if (burst_left == 0) begin
      int gap;
      gap = $urandom_range(0, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    waits_pending.push_back(sample_wait_time(b));
    burst_left--;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BASE_RATE:  base_rate_q = val;
      REG_COUNT_GAIN: count_gain_q = val;
      REG_EXTRA_RATE: extra_rate_q = val;
      REG_TOLERANCE:  tolerance_q = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (waits_pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic program_rates(logic [31:0] base, logic [31:0] gain,
                               logic [31:0] extra, logic [15:0] tol);
    drain();
    write_reg(REG_BASE_RATE, base);
    write_reg(REG_COUNT_GAIN, gain);
    write_reg(REG_EXTRA_RATE, extra);
    write_reg(REG_TOLERANCE, {16'd0, tol});
  endtask

  function automatic in_beat_t make_beat(logic [31:0] r, logic [31:0] h,
                                         logic [15:0] cur, logic [15:0] pop);
    in_beat_t b;
    b.uniform_sample = r;
    b.elapsed_time = h;
    b.current_count = cur;
    b.population = pop;
    return b;
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    int sel;
    sel = $urandom_range(0, 9);
    b.uniform_sample = (sel == 0) ? 32'hFFFF_FFFF : (sel == 1) ? 32'd0 : $urandom;
    b.elapsed_time = $urandom >> $urandom_range(0, 31);
    if (b.elapsed_time == 0) b.elapsed_time = 32'd1;
    b.current_count = (sel < 5) ? 16'($urandom_range(1, 16)) : 16'($urandom_range(1, 65535));
    b.population = (sel == 2) ? 16'd0 : (sel == 3) ? 16'hFFFF : 16'($urandom);
    return b;
  endfunction

  task automatic test_defaults;
    send_beat(make_beat(32'd0, 32'h0001_0000, 16'd1, 16'd0));
    send_beat(make_beat(32'hFFFF_FFFF, 32'h0001_0000, 16'd1, 16'd0));
    send_beat(make_beat(32'h8000_0000, 32'd1, 16'd1, 16'd1));
    send_beat(make_beat(32'h8000_0000, 32'hFFFF_FFFF, 16'd1, 16'hFFFF));
    send_beat(make_beat(32'h4000_0000, 32'h0002_0000, 16'hFFFF, 16'd3));
    send_beat(make_beat(32'hFFFF_FFFF, 32'd1, 16'hFFFF, 16'd0));
    send_beat(make_beat(32'h1234_5678, 32'd0, 16'd5, 16'd10));
    send_beat(make_beat(32'h1234_5678, 32'h0010_0000, 16'd0, 16'd10));
    send_beat(make_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 16'hFFFF));
    send_beat(make_beat(32'h0000_0001, 32'h0000_0100, 16'd200, 16'd0));
    drain();
    write_reg(REG_UNUSED_LO, 32'hDEAD_BEEF);
    write_reg(REG_UNUSED_HI, 32'h0);
  endtask

  task automatic test_rate_extremes;
    program_rates(32'd0, 32'hFFFF_FFFF, 32'd0, 16'd0);
    send_beat(make_beat(32'h8000_0000, 32'h0001_0000, 16'd1, 16'd0));
    send_beat(make_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd0));
    send_beat(make_beat(32'h0000_0000, 32'd1, 16'd1, 16'd1));
    send_beat(make_beat(32'h7FFF_FFFF, 32'h0100_0000, 16'd7, 16'hFFFF));
    program_rates(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 16'hFFFF);
    send_beat(make_beat(32'h8000_0000, 32'hFFFF_FFFF, 16'd1, 16'hFFFF));
    send_beat(make_beat(32'hFFFF_FFFF, 32'd1, 16'd1, 16'd0));
    send_beat(make_beat(32'h2000_0000, 32'h0000_8000, 16'hFFFF, 16'd9));
    program_rates(32'h0000_0100, 32'd1, 32'd0, 16'd0);
    send_beat(make_beat(32'hFFFF_FFFF, 32'h0000_0001, 16'd1, 16'd0));
    send_beat(make_beat(32'h0000_0001, 32'h0000_0010, 16'd2, 16'd0));
  endtask

  task automatic test_pressure;
    program_rates(32'h0001_0000, 32'h0001_0000, 32'h0000_4000, 16'd1);
    hold_req = 1'b1;
    repeat (12) send_beat(random_beat());
    drain();
    repeat (12) send_beat(random_beat());
  endtask

  task automatic test_random;
    for (int phase = 0; phase < 10; phase++) begin
      program_rates($urandom >> $urandom_range(0, 31),
                    ($urandom >> $urandom_range(0, 31)) | 32'd1,
                    ($urandom_range(0, 1) == 0) ? 32'd0 : ($urandom >> $urandom_range(0, 31)),
                    $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8)));
      repeat (120) send_beat(random_beat());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    idle_cycles = 0;
    error_count = 0;
    burst_left = 0;
    base_rate_q = 32'h0001_0000;
    count_gain_q = 32'h0001_0000;
    extra_rate_q = 32'd0;
    tolerance_q = 16'd1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_rate_extremes();
    test_pressure();
    test_random();
    drain();
    repeat (200) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_lambert_waiting_time_sampler: done, clean");
    end else begin
      $display("tb_lambert_waiting_time_sampler: done, errors");
    end
    $finish;
  end

endmodule
